@@ src/evr_pkg.sv @@
// shared types, constants and tables for the euler vector rotation unit
package evr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 31;
  localparam int CORDIC_DEPTH  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int SHW           = $clog2(ATAN_ENTRIES);

  localparam int VW   = 40;         // intermediate vector width
  localparam int CW   = 20;         // cordic x, y, z width
  localparam int PW   = VW + CW;    // product width
  localparam int MAGW = 48;         // magnitude of angle in q.32
  localparam int TW   = 36;         // reduced angle in q.32
  localparam int REDUCE_STEPS = 13; // quotient bits of the 2*pi reduction
  localparam int RSHW = $clog2(REDUCE_STEPS);

  localparam logic [MAGW-1:0]       TWO_PI_MAG     = 48'd26986075409;
  localparam logic signed [TW-1:0]  TWO_PI_Q32     = 36'sd26986075409;
  localparam logic signed [TW-1:0]  PI_Q32         = 36'sd13493037705;
  localparam logic signed [TW-1:0]  HALF_PI_Q32    = 36'sd6746518852;
  localparam logic signed [27:0]    DEG_TO_RAD_Q32 = 28'sd74961321;
  localparam logic signed [CW-1:0]  CORDIC_INIT_X  = 20'sd39797;

  localparam logic [1:0] PLANE_YZ = 2'd0;
  localparam logic [1:0] PLANE_ZX = 2'd1;
  localparam logic [1:0] PLANE_XY = 2'd2;

  localparam logic [1:0] ROT_FIRST = 2'd0;
  localparam logic [1:0] ROT_MID   = 2'd1;
  localparam logic [1:0] ROT_LAST  = 2'd2;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] yaw_angle;
    logic               angles_in_degrees;
    logic               reverse_order;
  } evr_in_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               saturated;
  } evr_out_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic            neg;
    logic [MAGW-1:0] mag;
  } red_lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  rev;
    vec3_t                 vec;
    red_lane_t [2:0]       lane;
  } red_t;

  typedef struct packed {
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cor_lane_t;

  typedef struct packed {
    logic            valid;
    logic            rev;
    vec3_t           vec;
    cor_lane_t [2:0] lane;
  } cor_t;

  typedef struct packed {
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] c;
  } sc_t;

  typedef struct packed {
    logic      valid;
    logic      rev;
    vec3_t     vec;
    sc_t [2:0] sc;
  } rot_t;

  function automatic logic [CW-1:0] atan_q16(input logic [SHW-1:0] i);
    logic [CW-1:0] v;
    case (i)
      5'd0:    v = 20'd51472;
      5'd1:    v = 20'd30386;
      5'd2:    v = 20'd16055;
      5'd3:    v = 20'd8150;
      5'd4:    v = 20'd4091;
      5'd5:    v = 20'd2047;
      5'd6:    v = 20'd1024;
      5'd7:    v = 20'd512;
      5'd8:    v = 20'd256;
      5'd9:    v = 20'd128;
      5'd10:   v = 20'd64;
      5'd11:   v = 20'd32;
      5'd12:   v = 20'd16;
      5'd13:   v = 20'd8;
      5'd14:   v = 20'd4;
      5'd15:   v = 20'd2;
      5'd16:   v = 20'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/evr_reduce_cell.sv @@
// one compare-subtract step of the modulo 2*pi angle reduction, three lanes
module evr_reduce_cell import evr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [RSHW-1:0] shift,
  input  red_t            d_in,
  output red_t            d_out
);

  logic [MAGW-1:0] divisor;
  red_t            nxt;

  always_comb begin
    divisor = TWO_PI_MAG << shift;
    nxt = d_in;
    for (int k = 0; k < 3; k++) begin
      if (d_in.lane[k].mag >= divisor) begin
        nxt.lane[k].mag = d_in.lane[k].mag - divisor;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rev  <= nxt.rev;
      d_out.vec  <= nxt.vec;
      d_out.lane <= nxt.lane;
    end
  end

endmodule

@@ src/evr_cordic_cell.sv @@
// one rotation-mode cordic iteration for the three angle lanes
module evr_cordic_cell import evr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [SHW-1:0] step,
  input  cor_t           d_in,
  output cor_t           d_out
);

  logic signed [CW-1:0] xs [3];
  logic signed [CW-1:0] ys [3];
  logic signed [CW-1:0] zs [3];
  logic signed [CW-1:0] dx [3];
  logic signed [CW-1:0] dy [3];
  logic signed [CW-1:0] at;
  cor_t                 nxt;

  always_comb begin
    nxt = d_in;
    at  = $signed(atan_q16(step));
    for (int k = 0; k < 3; k++) begin
      xs[k] = d_in.lane[k].x;
      ys[k] = d_in.lane[k].y;
      zs[k] = d_in.lane[k].z;
      dx[k] = ys[k] >>> step;
      dy[k] = xs[k] >>> step;
      if (!zs[k][CW-1]) begin
        nxt.lane[k].x = xs[k] - dx[k];
        nxt.lane[k].y = ys[k] + dy[k];
        nxt.lane[k].z = zs[k] - at;
      end else begin
        nxt.lane[k].x = xs[k] + dx[k];
        nxt.lane[k].y = ys[k] - dy[k];
        nxt.lane[k].z = zs[k] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rev  <= nxt.rev;
      d_out.vec  <= nxt.vec;
      d_out.lane <= nxt.lane;
    end
  end

endmodule

@@ src/evr_rotate_cell.sv @@
// one elementary plane rotation: products in the first stage, sum and round in the second
module evr_rotate_cell import evr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [1:0] pos,
  input  rot_t       d_in,
  output rot_t       d_out
);

  logic [1:0]           plane;
  logic signed [VW-1:0] a;
  logic signed [VW-1:0] b;
  sc_t                  sc;

  rot_t                 p_d;
  logic [1:0]           p_plane;
  logic signed [PW-1:0] p_ca;
  logic signed [PW-1:0] p_sb;
  logic signed [PW-1:0] p_sa;
  logic signed [PW-1:0] p_cb;

  logic signed [PW:0]   sum_a;
  logic signed [PW:0]   sum_b;
  logic signed [VW-1:0] na;
  logic signed [VW-1:0] nb;
  rot_t                 nxt;

  always_comb begin
    case (pos)
      ROT_FIRST: plane = d_in.rev ? PLANE_XY : PLANE_YZ;
      ROT_MID:   plane = PLANE_ZX;
      default:   plane = d_in.rev ? PLANE_YZ : PLANE_XY;
    endcase
    case (plane)
      PLANE_YZ: begin
        a  = d_in.vec.y;
        b  = d_in.vec.z;
        sc = d_in.sc[LANE_ROLL];
      end
      PLANE_ZX: begin
        a  = d_in.vec.z;
        b  = d_in.vec.x;
        sc = d_in.sc[LANE_PITCH];
      end
      default: begin
        a  = d_in.vec.x;
        b  = d_in.vec.y;
        sc = d_in.sc[LANE_YAW];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_d.valid   <= 1'b0;
      d_out.valid <= 1'b0;
    end else if (en) begin
      p_d.valid   <= d_in.valid;
      d_out.valid <= p_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_d.rev <= d_in.rev;
      p_d.vec <= d_in.vec;
      p_d.sc  <= d_in.sc;
      p_plane <= plane;
      p_ca    <= PW'(sc.c * a);
      p_sb    <= PW'(sc.s * b);
      p_sa    <= PW'(sc.s * a);
      p_cb    <= PW'(sc.c * b);
    end
  end

  // round to q16.16, ties toward plus infinity
  always_comb begin
    sum_a = (PW+1)'(p_ca) - (PW+1)'(p_sb) + (PW+1)'(32768);
    sum_b = (PW+1)'(p_sa) + (PW+1)'(p_cb) + (PW+1)'(32768);
    na    = VW'(sum_a >>> 16);
    nb    = VW'(sum_b >>> 16);
    nxt   = p_d;
    case (p_plane)
      PLANE_YZ: begin
        nxt.vec.y = na;
        nxt.vec.z = nb;
      end
      PLANE_ZX: begin
        nxt.vec.z = na;
        nxt.vec.x = nb;
      end
      default: begin
        nxt.vec.x = na;
        nxt.vec.y = nb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rev <= nxt.rev;
      d_out.vec <= nxt.vec;
      d_out.sc  <= nxt.sc;
    end
  end

endmodule

@@ src/euler_vector_rotation_unit.sv @@
// throughput: one item per cycle while no result is held waiting; 2 input stages,
// 13 reduction cells, 2 fold stages, one cordic cell per stage, a sign stage,
// 3 two-stage rotation cells and the output register
// the whole pipeline advances together and holds while a result waits to be taken
// synchronous reset clears all valid bits; payload registers are not reset
module euler_vector_rotation_unit import evr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  evr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output evr_out_t out_data
);

  logic en;

  // stage a: degree conversion product
  logic                a_valid;
  evr_in_t             a_item;
  logic [2:0][59:0]    a_prod;
  logic signed [31:0]  in_ang [3];

  // stage b result feeds the reduction chain
  red_t                red_chain [REDUCE_STEPS+1];
  logic signed [31:0]  b_ang  [3];
  logic signed [63:0]  b_rnd  [3];
  logic signed [32:0]  b_a    [3];
  logic [32:0]         b_abs  [3];
  red_t                b_nxt;

  // fold stages
  logic                f1_valid;
  logic                f1_rev;
  vec3_t               f1_vec;
  logic [2:0][TW-1:0]  f1_t;
  logic signed [TW-1:0] f1_r [3];
  logic signed [TW-1:0] f1_w [3];
  logic [2:0][TW-1:0]  f1_t_next;
  logic signed [TW-1:0] f2_t [3];
  logic signed [TW-1:0] f2_f [3];
  logic signed [TW-1:0] f2_z [3];
  cor_t                f2_nxt;

  cor_t                cor_chain [CORDIC_DEPTH+1];
  rot_t                rot_chain [4];
  rot_t                s_nxt;

  logic signed [VW-1:0] cl_v [3];
  logic [31:0]          cl_o [3];
  logic [2:0]           cl_sat;
  logic signed [VW-1:0] max_v;
  logic signed [VW-1:0] min_v;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    in_ang[LANE_ROLL]  = in_data.roll_angle;
    in_ang[LANE_PITCH] = in_data.pitch_angle;
    in_ang[LANE_YAW]   = in_data.yaw_angle;
    b_ang[LANE_ROLL]   = a_item.roll_angle;
    b_ang[LANE_PITCH]  = a_item.pitch_angle;
    b_ang[LANE_YAW]    = a_item.yaw_angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_data;
      for (int k = 0; k < 3; k++) begin
        a_prod[k] <= 60'(in_ang[k] * DEG_TO_RAD_Q32);
      end
    end
  end

  // stage b: round to q16.16, negate for reverse order, split into sign and q.32 magnitude
  always_comb begin
    b_nxt.valid = a_valid;
    b_nxt.rev   = a_item.reverse_order;
    b_nxt.vec.x = VW'(a_item.vec_x);
    b_nxt.vec.y = VW'(a_item.vec_y);
    b_nxt.vec.z = VW'(a_item.vec_z);
    for (int k = 0; k < 3; k++) begin
      b_rnd[k] = (64'($signed(a_prod[k])) + 64'sd2147483648) >>> 32;
      b_a[k]   = a_item.angles_in_degrees ? 33'(b_rnd[k]) : 33'(b_ang[k]);
      if (a_item.reverse_order) begin
        b_a[k] = -b_a[k];
      end
      b_abs[k] = b_a[k][32] ? 33'(-b_a[k]) : 33'(b_a[k]);
      b_nxt.lane[k].neg = b_a[k][32];
      b_nxt.lane[k].mag = {b_abs[k][31:0], 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_chain[0].valid <= 1'b0;
    end else if (en) begin
      red_chain[0].valid <= b_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_chain[0].rev  <= b_nxt.rev;
      red_chain[0].vec  <= b_nxt.vec;
      red_chain[0].lane <= b_nxt.lane;
    end
  end

  for (genvar g = 0; g < REDUCE_STEPS; g++) begin : g_reduce
    evr_reduce_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .shift (RSHW'(REDUCE_STEPS - 1 - g)),
      .d_in  (red_chain[g]),
      .d_out (red_chain[g+1])
    );
  end

  // f1: wrap the remainder into [-pi, pi] with the sign of the angle
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f1_r[k] = TW'(red_chain[REDUCE_STEPS].lane[k].mag);
      f1_w[k] = (f1_r[k] > PI_Q32) ? f1_r[k] - TWO_PI_Q32 : f1_r[k];
      f1_t_next[k] = red_chain[REDUCE_STEPS].lane[k].neg ? -f1_w[k] : f1_w[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= red_chain[REDUCE_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_rev <= red_chain[REDUCE_STEPS].rev;
      f1_vec <= red_chain[REDUCE_STEPS].vec;
      f1_t   <= f1_t_next;
    end
  end

  // f2: fold into [-pi/2, pi/2] and round the start angle to q16.16
  always_comb begin
    f2_nxt.valid = f1_valid;
    f2_nxt.rev   = f1_rev;
    f2_nxt.vec   = f1_vec;
    for (int k = 0; k < 3; k++) begin
      f2_t[k] = $signed(f1_t[k]);
      if (f2_t[k] > HALF_PI_Q32) begin
        f2_f[k] = f2_t[k] - PI_Q32;
        f2_nxt.lane[k].flip = 1'b1;
      end else if (f2_t[k] < -HALF_PI_Q32) begin
        f2_f[k] = f2_t[k] + PI_Q32;
        f2_nxt.lane[k].flip = 1'b1;
      end else begin
        f2_f[k] = f2_t[k];
        f2_nxt.lane[k].flip = 1'b0;
      end
      f2_z[k] = (f2_f[k] + TW'(32768)) >>> 16;
      f2_nxt.lane[k].x = CORDIC_INIT_X;
      f2_nxt.lane[k].y = '0;
      f2_nxt.lane[k].z = CW'(f2_z[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cor_chain[0].valid <= 1'b0;
    end else if (en) begin
      cor_chain[0].valid <= f2_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor_chain[0].rev  <= f2_nxt.rev;
      cor_chain[0].vec  <= f2_nxt.vec;
      cor_chain[0].lane <= f2_nxt.lane;
    end
  end

  for (genvar g = 0; g < CORDIC_DEPTH; g++) begin : g_cordic
    evr_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .step  (SHW'(g)),
      .d_in  (cor_chain[g]),
      .d_out (cor_chain[g+1])
    );
  end

  // sign correction for angles that were folded by pi
  always_comb begin
    s_nxt.valid = cor_chain[CORDIC_DEPTH].valid;
    s_nxt.rev   = cor_chain[CORDIC_DEPTH].rev;
    s_nxt.vec   = cor_chain[CORDIC_DEPTH].vec;
    for (int k = 0; k < 3; k++) begin
      if (cor_chain[CORDIC_DEPTH].lane[k].flip) begin
        s_nxt.sc[k].s = -cor_chain[CORDIC_DEPTH].lane[k].y;
        s_nxt.sc[k].c = -cor_chain[CORDIC_DEPTH].lane[k].x;
      end else begin
        s_nxt.sc[k].s = cor_chain[CORDIC_DEPTH].lane[k].y;
        s_nxt.sc[k].c = cor_chain[CORDIC_DEPTH].lane[k].x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_chain[0].valid <= 1'b0;
    end else if (en) begin
      rot_chain[0].valid <= s_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_chain[0].rev <= s_nxt.rev;
      rot_chain[0].vec <= s_nxt.vec;
      rot_chain[0].sc  <= s_nxt.sc;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_rotate
    evr_rotate_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .pos   (2'(g)),
      .d_in  (rot_chain[g]),
      .d_out (rot_chain[g+1])
    );
  end

  // clip each component to 32 bits
  always_comb begin
    max_v = VW'(32'sh7fffffff);
    min_v = VW'(-33'sd2147483648);
    cl_v[0] = rot_chain[3].vec.x;
    cl_v[1] = rot_chain[3].vec.y;
    cl_v[2] = rot_chain[3].vec.z;
    for (int k = 0; k < 3; k++) begin
      if (cl_v[k] > max_v) begin
        cl_o[k]   = 32'h7fffffff;
        cl_sat[k] = 1'b1;
      end else if (cl_v[k] < min_v) begin
        cl_o[k]   = 32'h80000000;
        cl_sat[k] = 1'b1;
      end else begin
        cl_o[k]   = cl_v[k][31:0];
        cl_sat[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rot_chain[3].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.rot_x     <= cl_o[0];
      out_data.rot_y     <= cl_o[1];
      out_data.rot_z     <= cl_o[2];
      out_data.saturated <= |cl_sat;
    end
  end

endmodule

@@ src/evr_checker.sv @@
// port-level checks for the euler vector rotation unit, bound to the top level
module evr_checker import evr_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input evr_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input evr_out_t out_data
);

  // a stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // a waiting input item keeps its valid and payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // input is only held off by a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output backpressure");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind euler_vector_rotation_unit evr_checker u_evr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/testbench.sv @@
// testbench for the euler vector rotation unit: directed and random stimulus checked against a built-in predictor
module testbench;
  import evr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  N_RANDOM   = 1230;
  localparam int  IDLE_LIMIT = 4000;
  localparam longint RAD_PI   = 205887;  // pi in q16.16
  localparam longint RAD_HALF = 102944;
  localparam longint DEG_ONE  = 65536;
  localparam longint ATAN_TBL [0:30] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0,
                                         0, 0, 0, 0, 0, 0, 0, 0, 0};

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  evr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  evr_out_t out_data;

  evr_in_t  pending_items[$];
  evr_out_t rotated_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       send_gap = 0;
  int       take_gap = 0;

  euler_vector_rotation_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // mostly no gap, otherwise mostly short gaps and a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint t, x, y, z, dx, dy;
    bit flip;
    t = (ang * 65536) % TWO_PI_Q32;
    flip = 0;
    if (t > PI_Q32) t -= TWO_PI_Q32;
    else if (t < -PI_Q32) t += TWO_PI_Q32;
    if (t > HALF_PI_Q32) begin
      t -= PI_Q32;
      flip = 1;
    end else if (t < -HALF_PI_Q32) begin
      t += PI_Q32;
      flip = 1;
    end
    z = (t + 32768) >>> 16;
    x = 39797;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TBL[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TBL[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic void turn_plane(inout longint a, inout longint b,
                                     input longint s, input longint c);
    longint na, nb;
    na = (c * a - s * b + 32768) >>> 16;
    nb = (s * a + c * b + 32768) >>> 16;
    a = na;
    b = nb;
  endfunction

  function automatic logic signed [31:0] clip_q16(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic evr_out_t rotate_vector(input evr_in_t it);
    longint vx, vy, vz, sr, cr, sp, cp, sy, cy;
    longint ang[3];
    bit sat;
    evr_out_t r;
    vx = it.vec_x;
    vy = it.vec_y;
    vz = it.vec_z;
    ang[0] = it.roll_angle;
    ang[1] = it.pitch_angle;
    ang[2] = it.yaw_angle;
    sat = 0;
    for (int k = 0; k < 3; k++) begin
      if (it.angles_in_degrees) ang[k] = (ang[k] * 74961321 + 64'sd2147483648) >>> 32;
      if (it.reverse_order) ang[k] = -ang[k];
    end
    sin_cos(ang[0], sr, cr);
    sin_cos(ang[1], sp, cp);
    sin_cos(ang[2], sy, cy);
    if (!it.reverse_order) turn_plane(vy, vz, sr, cr);
    else turn_plane(vx, vy, sy, cy);
    turn_plane(vz, vx, sp, cp);
    if (!it.reverse_order) turn_plane(vx, vy, sy, cy);
    else turn_plane(vy, vz, sr, cr);
    r.rot_x = clip_q16(vx, sat);
    r.rot_y = clip_q16(vy, sat);
    r.rot_z = clip_q16(vz, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic evr_in_t make_item(longint x, longint y, longint z, longint ra,
                                        longint pa, longint ya, bit deg, bit rev);
    evr_in_t it;
    it.vec_x = x[31:0];
    it.vec_y = y[31:0];
    it.vec_z = z[31:0];
    it.roll_angle = ra[31:0];
    it.pitch_angle = pa[31:0];
    it.yaw_angle = ya[31:0];
    it.angles_in_degrees = deg;
    it.reverse_order = rev;
    return it;
  endfunction

  function automatic longint rand_angle(bit deg);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $signed($urandom());
    if (deg) return longint'($signed($urandom_range(0, 720 * 65536))) - 360 * DEG_ONE;
    return longint'($signed($urandom_range(0, 4 * RAD_PI))) - 2 * RAD_PI;
  endfunction

  function automatic longint rand_comp();
    if ($urandom_range(0, 2) == 0) return $signed($urandom());
    return longint'($signed($urandom_range(0, 2000 * 65536))) - 1000 * 65536;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    evr_out_t want;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (in_valid && in_ready) rotated_q.push_back(rotate_vector(in_data));
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          $error("result item with nothing expected");
          mismatches++;
        end else begin
          want = rotated_q.pop_front();
          if (out_data.rot_x !== want.rot_x) begin
            $error("rot_x expected %0d got %0d", want.rot_x, out_data.rot_x);
            mismatches++;
          end
          if (out_data.rot_y !== want.rot_y) begin
            $error("rot_y expected %0d got %0d", want.rot_y, out_data.rot_y);
            mismatches++;
          end
          if (out_data.rot_z !== want.rot_z) begin
            $error("rot_z expected %0d got %0d", want.rot_z, out_data.rot_z);
            mismatches++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated expected %0d got %0d", want.saturated, out_data.saturated);
            mismatches++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 3) == 0) take_gap <= pick_gap();
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    longint big, neg;
    bit deg;
    big = 64'sd2147483647;
    neg = -64'sd2147483648;
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    in_data = '0;
    // extremes of the vector and the angles, fold boundaries, degree mode, reverse order
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(big, neg, big, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(neg, neg, neg, 0, 0, 0, 1, 1));
    pending_items.push_back(make_item(65536, 2 * 65536, 3 * 65536, big, neg, big, 0, 0));
    pending_items.push_back(make_item(65536, 2 * 65536, 3 * 65536, neg, big, neg, 1, 0));
    pending_items.push_back(make_item(65536, 65536, 65536, big, big, neg, 1, 1));
    pending_items.push_back(make_item(65536, 0, 0, RAD_PI, -RAD_PI, RAD_HALF, 0, 0));
    pending_items.push_back(make_item(0, 65536, 0, RAD_HALF + 1, -RAD_HALF, -RAD_HALF - 1,
                                      0, 1));
    pending_items.push_back(make_item(0, 0, 65536, RAD_PI + 1, -RAD_PI - 1, 2 * RAD_PI, 0, 0));
    pending_items.push_back(make_item(65536, 65536, 0, 90 * DEG_ONE, 180 * DEG_ONE,
                                      -180 * DEG_ONE, 1, 0));
    pending_items.push_back(make_item(65536, 65536, 0, 90 * DEG_ONE, 180 * DEG_ONE,
                                      -180 * DEG_ONE, 1, 1));
    pending_items.push_back(make_item(big, big, big, 45 * DEG_ONE, 45 * DEG_ONE,
                                      45 * DEG_ONE, 1, 0));
    pending_items.push_back(make_item(neg, neg, neg, -45 * DEG_ONE, 30 * DEG_ONE,
                                      60 * DEG_ONE, 1, 1));
    pending_items.push_back(make_item(big, neg, 0, 0, 0, 45 * DEG_ONE, 1, 0));
    pending_items.push_back(make_item(-1, 1, -1, 1, -1, 1, 0, 0));
    pending_items.push_back(make_item(-1, 1, -1, 1, -1, 1, 1, 1));
    pending_items.push_back(make_item(123456, -654321, 999999, 360 * DEG_ONE,
                                      -720 * DEG_ONE, 270 * DEG_ONE, 1, 0));
    pending_items.push_back(make_item(-77777, 55555, -33333, 51472, -30386, 102943, 0, 1));
    for (int n = 0; n < N_RANDOM; n++) begin
      deg = $urandom_range(0, 1);
      pending_items.push_back(make_item(rand_comp(), rand_comp(), rand_comp(),
                                        rand_angle(deg), rand_angle(deg), rand_angle(deg),
                                        deg, $urandom_range(0, 1)));
    end
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (pending_items.size() > 0 || in_valid || rotated_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && !out_valid) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
